@@ rtl/core/wsd_pkg.sv @@
// shared types and constants for the wav stream deframer
package wsd_pkg;

  localparam int unsigned MAX_SAMPLE_BYTES = 4;
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;
  localparam logic [31:0] FMT_BODY_BYTES = 32'd16;
  localparam logic [7:0]  PCM_BIAS = 8'd128;
  localparam int unsigned BITS_PER_BYTE = 8;
  localparam logic [5:0]  DIV_STEPS = 6'd32;

  localparam logic [3:0] IDX_TAG_END  = 4'd3;
  localparam logic [3:0] IDX_RIFF_END = 4'd11;
  localparam logic [3:0] IDX_HDR_END  = 4'd7;
  localparam logic [3:0] IDX_FMT_END  = 4'd15;
  localparam logic [3:0] IDX_CH_LO    = 4'd2;
  localparam logic [3:0] IDX_CH_HI    = 4'd3;
  localparam logic [3:0] IDX_RATE_LO  = 4'd4;
  localparam logic [3:0] IDX_RATE_HI  = 4'd7;

  typedef enum logic [2:0] {
    KIND_SAMPLE     = 3'd0,
    KIND_FORMAT     = 3'd1,
    KIND_DATA       = 3'd2,
    KIND_BAD_HEADER = 3'd3,
    KIND_BAD_FORMAT = 3'd4
  } kind_t;

  typedef enum logic [7:0] {
    PH_RIFF = 8'b0000_0001,
    PH_HDR  = 8'b0000_0010,
    PH_FMT  = 8'b0000_0100,
    PH_SKIP = 8'b0000_1000,
    PH_DATA = 8'b0001_0000,
    PH_DIV  = 8'b0010_0000,
    PH_DONE = 8'b0100_0000,
    PH_ERR  = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       restart;
  } in_beat_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] pcm_sample;
    logic               last_sample;
    logic [15:0]        channel_count;
    logic [31:0]        rate_hz;
    logic [31:0]        total_samples;
  } out_beat_t;

  typedef struct packed {
    logic   take;
    phase_t phase;
    logic   emit;
    kind_t  kind;
    logic   div_start;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       restart;
    logic       out_valid;
    logic [3:0] idx;
    logic       tag_riff;
    logic       tag_wave;
    logic       tag_fmt;
    logic       tag_data;
    logic       len_lt16;
    logic       len_zero;
    logic       fmt_ok;
    logic       nbytes_ok;
    logic       fmt_left_zero;
    logic       left_one;
    logic       sample_done;
    logic       last;
    logic       len_lt_sb;
    logic       div_done;
  } dp_sts_t;

endpackage

@@ rtl/core/wsd_ctrl.sv @@
// parse phase state machine and command decode
module wsd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              out_stall,
  input  wsd_pkg::dp_sts_t  sts,
  output logic              in_stall,
  output wsd_pkg::ctrl_cmd_t cmd
);
  import wsd_pkg::*;

  phase_t phase, phase_next, eph;
  logic   busy, out_block, take;

  always_comb begin
    busy      = (phase == PH_DIV);
    out_block = sts.out_valid & out_stall;
    in_stall  = busy | out_block;
    take      = in_valid & ~in_stall;
    eph       = (take && sts.restart) ? PH_RIFF : phase;
    phase_next    = phase;
    cmd.take      = take;
    cmd.phase     = eph;
    cmd.emit      = 1'b0;
    cmd.kind      = KIND_SAMPLE;
    cmd.div_start = 1'b0;
    if (take) begin
      phase_next = eph;
      unique case (eph)
        PH_RIFF: begin
          if (sts.idx == IDX_TAG_END && !sts.tag_riff) begin
            cmd.emit = 1'b1; cmd.kind = KIND_BAD_HEADER; phase_next = PH_ERR;
          end else if (sts.idx == IDX_RIFF_END) begin
            if (!sts.tag_wave) begin
              cmd.emit = 1'b1; cmd.kind = KIND_BAD_HEADER; phase_next = PH_ERR;
            end else begin
              phase_next = PH_HDR;
            end
          end
        end
        PH_HDR: begin
          if (sts.idx == IDX_HDR_END) begin
            if (sts.tag_fmt) begin
              if (sts.len_lt16) begin
                cmd.emit = 1'b1; cmd.kind = KIND_BAD_FORMAT; phase_next = PH_ERR;
              end else begin
                phase_next = PH_FMT;
              end
            end else if (sts.tag_data) begin
              if (!sts.fmt_ok) begin
                cmd.emit = 1'b1; cmd.kind = KIND_BAD_FORMAT; phase_next = PH_ERR;
              end else begin
                cmd.div_start = 1'b1; phase_next = PH_DIV;
              end
            end else begin
              phase_next = sts.len_zero ? PH_HDR : PH_SKIP;
            end
          end
        end
        PH_FMT: begin
          if (sts.idx == IDX_FMT_END) begin
            cmd.emit = 1'b1;
            if (!sts.nbytes_ok) begin
              cmd.kind = KIND_BAD_FORMAT; phase_next = PH_ERR;
            end else begin
              cmd.kind = KIND_FORMAT;
              phase_next = sts.fmt_left_zero ? PH_HDR : PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          if (sts.left_one) phase_next = PH_HDR;
        end
        PH_DATA: begin
          if (sts.sample_done) begin
            cmd.emit = 1'b1; cmd.kind = KIND_SAMPLE;
            if (sts.last) phase_next = PH_DONE;
          end
        end
        default: phase_next = eph;
      endcase
    end else if (busy && sts.div_done && !out_block) begin
      cmd.emit   = 1'b1;
      cmd.kind   = KIND_DATA;
      phase_next = sts.len_lt_sb ? PH_DONE : PH_DATA;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_RIFF;
    end else begin
      phase <= phase_next;
    end
  end

`ifndef SYNTHESIS
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ERR && !(take && sts.restart)) |=> phase == PH_ERR)
    else $error("error phase left without restart");
  a_div_enter: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> phase == PH_DIV)
    else $error("divide start did not enter divide phase");
  a_err_quiet: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ERR && !(take && sts.restart)) |-> !cmd.emit)
    else $error("result emitted while error latched");
`endif
endmodule

@@ rtl/core/wsd_dp.sv @@
// field registers, tag compares, divider and output register
module wsd_dp (
  input  logic               clk,
  input  logic               rst,
  input  wsd_pkg::in_beat_t  in_data,
  input  logic               out_stall,
  input  wsd_pkg::ctrl_cmd_t cmd,
  output wsd_pkg::dp_sts_t   sts,
  output logic               out_valid,
  output wsd_pkg::out_beat_t out_data
);
  import wsd_pkg::*;

  logic [3:0]  idx, idx_next, e_idx;
  logic [31:0] tag, tag_next, e_tag;
  logic [31:0] len, len_next, e_len;
  logic [31:0] left, left_next, e_left, left_dec;
  logic        fmt_seen, fmt_seen_next, e_fmt_seen;
  logic [2:0]  sb, sb_next, e_sb;
  logic [15:0] chan, chan_next, e_chan;
  logic [31:0] rate, rate_next, e_rate;
  logic [31:0] asm_q, asm_next, e_asm;
  logic [1:0]  bis, bis_next, e_bis;
  logic [12:0] nbytes;
  logic [7:0]  b;
  logic        rs;
  logic [31:0] div_q;
  logic [2:0]  div_rem;
  logic [5:0]  div_cnt;
  logic [3:0]  div_r4;
  logic        div_ge;
  logic [15:0] pcm;

  always_comb begin
    b      = in_data.stream_byte;
    rs     = cmd.take & in_data.restart;
    e_idx  = rs ? '0 : idx;
    e_tag  = rs ? '0 : tag;
    e_len  = rs ? '0 : len;
    e_left = rs ? '0 : left;
    e_fmt_seen = rs ? 1'b0 : fmt_seen;
    e_sb   = rs ? '0 : sb;
    e_chan = rs ? '0 : chan;
    e_rate = rs ? '0 : rate;
    e_asm  = rs ? '0 : asm_q;
    e_bis  = rs ? '0 : bis;

    left_dec = e_left - 32'd1;
    asm_next = {b, e_asm[31:8]};
    tag_next = e_tag;
    len_next = e_len;
    if (cmd.phase == PH_RIFF || (cmd.phase == PH_HDR && e_idx < 4'd4))
      tag_next = {e_tag[23:0], b};
    else if (cmd.phase == PH_FMT)
      tag_next = {b, e_tag[31:8]};
    if (cmd.phase == PH_HDR && e_idx >= 4'd4)
      len_next = {b, e_len[31:8]};
    // bits per sample over eight
    nbytes = tag_next[31:19];

    sts.restart   = in_data.restart;
    sts.out_valid = out_valid;
    sts.idx       = e_idx;
    sts.tag_riff  = (tag_next == TAG_RIFF);
    sts.tag_wave  = (tag_next == TAG_WAVE);
    sts.tag_fmt   = (tag_next == TAG_FMT);
    sts.tag_data  = (tag_next == TAG_DATA);
    sts.len_lt16  = (len_next < FMT_BODY_BYTES);
    sts.len_zero  = (len_next == '0);
    sts.fmt_ok    = e_fmt_seen && (e_sb != '0);
    sts.nbytes_ok = (nbytes != '0) && (nbytes <= 13'(MAX_SAMPLE_BYTES));
    sts.fmt_left_zero = (e_len == FMT_BODY_BYTES);
    sts.left_one  = (left_dec == '0);
    sts.sample_done = ({1'b0, e_bis} + 3'd1) >= e_sb;
    sts.last      = left_dec < {29'd0, e_sb};
    sts.len_lt_sb = len < {29'd0, sb};
    sts.div_done  = (div_cnt == '0);

    idx_next = e_idx; left_next = e_left; fmt_seen_next = e_fmt_seen;
    sb_next = e_sb; chan_next = e_chan; rate_next = e_rate; bis_next = e_bis;
    unique case (cmd.phase)
      PH_RIFF: idx_next = (e_idx == IDX_RIFF_END) ? '0 : e_idx + 4'd1;
      PH_HDR: begin
        idx_next = (e_idx == IDX_HDR_END) ? '0 : e_idx + 4'd1;
        if (e_idx == IDX_HDR_END) begin
          left_next = len_next;
          bis_next  = '0;
        end
      end
      PH_FMT: begin
        idx_next = e_idx + 4'd1;
        if (e_idx == IDX_CH_LO) chan_next = {8'd0, b};
        else if (e_idx == IDX_CH_HI) chan_next = {b, e_chan[7:0]};
        else if (e_idx >= IDX_RATE_LO && e_idx <= IDX_RATE_HI)
          rate_next = {b, e_rate[31:8]};
        if (e_idx == IDX_FMT_END && sts.nbytes_ok) begin
          sb_next       = nbytes[2:0];
          fmt_seen_next = 1'b1;
          left_next     = e_len - FMT_BODY_BYTES;
        end
      end
      PH_SKIP: left_next = left_dec;
      PH_DATA: begin
        left_next = left_dec;
        bis_next  = sts.sample_done ? '0 : e_bis + 2'd1;
      end
      default: idx_next = e_idx;
    endcase

    div_r4 = {div_rem, div_q[31]};
    div_ge = div_r4 >= {1'b0, sb};

    if (sb == 3'd1) pcm = {asm_next[31:24] ^ PCM_BIAS, 8'd0};
    else            pcm = asm_next[31:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0; tag <= '0; len <= '0; left <= '0; fmt_seen <= 1'b0;
      sb <= '0; chan <= '0; rate <= '0; asm_q <= '0; bis <= '0;
      div_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.take) begin
        idx <= idx_next; tag <= tag_next; len <= len_next; left <= left_next;
        fmt_seen <= fmt_seen_next; sb <= sb_next; chan <= chan_next;
        rate <= rate_next; bis <= bis_next;
        if (cmd.phase == PH_DATA) asm_q <= asm_next;
        else if (cmd.phase == PH_HDR) asm_q <= '0;
        else asm_q <= e_asm;
      end
      // one quotient bit per cycle
      if (cmd.div_start) begin
        div_cnt <= DIV_STEPS;
      end else if (div_cnt != '0) begin
        div_cnt <= div_cnt - 6'd1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_q   <= len_next;
      div_rem <= '0;
    end else if (div_cnt != '0) begin
      div_q   <= {div_q[30:0], div_ge};
      div_rem <= div_ge ? 3'(div_r4 - {1'b0, sb}) : div_r4[2:0];
    end
    if (cmd.emit) begin
      out_data.kind          <= cmd.kind;
      out_data.pcm_sample    <= (cmd.kind == KIND_SAMPLE) ? pcm : '0;
      out_data.last_sample   <= (cmd.kind == KIND_SAMPLE) ? sts.last : 1'b0;
      out_data.channel_count <= cmd.take ? chan_next : chan;
      out_data.rate_hz       <= cmd.take ? rate_next : rate;
      out_data.total_samples <= (cmd.kind == KIND_DATA) ? div_q : '0;
    end
  end
endmodule

@@ rtl/core/wav_stream_deframer_core.sv @@
// top level of the wav stream deframer
//  channel  direction  handshake            payload
//  in       sink       in_valid / in_stall  in_beat_t (stream_byte, restart)
//  out      source     out_valid/out_stall  out_beat_t (kind .. total_samples)
// one byte per cycle unless a held result beat is stalled; a data chunk header
// stalls the input while the bit-serial divider forms the sample total
// rst is synchronous; restart on a beat resets the parser before that byte
// in_stall rises while dividing or while a held result beat is stalled
module wav_stream_deframer_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  wsd_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output wsd_pkg::out_beat_t out_data
);
  import wsd_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  wsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  wsd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );
endmodule
